### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands used by hsvrgb_checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, ignored while rst is high
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication, ignored while rst is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

// next-cycle implication that is also checked during reset
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

### rtl/core/hsvrgb_pkg.sv
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// shared widths, defaults and transaction types of the hsv to rgb converter
// ----------------------------------------------------------------------------
`default_nettype none

package hsvrgb_pkg;

   localparam int HUE_BITS          = 13;
   localparam int CHANNEL_BITS      = 8;
   localparam int HUE_FRAC_BITS_DEF = 4;
   localparam int STAGES            = 7;

   typedef struct packed {
      logic [HUE_BITS-1:0]     hue;
      logic [CHANNEL_BITS-1:0] saturation;
      logic [CHANNEL_BITS-1:0] brightness;
   } req_type;

   typedef struct packed {
      logic [CHANNEL_BITS-1:0] red;
      logic [CHANNEL_BITS-1:0] green;
      logic [CHANNEL_BITS-1:0] blue;
   } rsp_type;

endpackage

`default_nettype wire

### rtl/core/hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// converts one hue/saturation/value color to red/green/blue per transaction
//
//   channel   direction   handshake            payload
//   req_      in          req_valid/req_stall  hsvrgb_pkg::req_type
//   rsp_      out         rsp_valid/rsp_stall  hsvrgb_pkg::rsp_type
//
// one transaction per cycle sustained while rsp_stall is low; each result passes
// through the seven-stage multiply/divide-by-constant pipeline
// reset clears only the stage valid bits; payload registers are not reset
// stalled stages hold, empty stages fill, so bubbles close up under rsp_stall
// req_stall rises only when every stage holds a transaction and rsp is stalled
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_converter #(
   parameter int HUE_FRAC_BITS = hsvrgb_pkg::HUE_FRAC_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_stall,
   input  wire hsvrgb_pkg::req_type  req_payload,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   output      hsvrgb_pkg::rsp_type  rsp_payload
);

   localparam int NS = hsvrgb_pkg::STAGES;

   logic [NS-1:0] valid_ff, valid_in;
   logic [NS-1:0] adv_in;

   always_comb begin
      adv_in[NS-1] = !valid_ff[NS-1] || !rsp_stall;
      for (int k = NS - 2; k >= 0; k--) begin
         adv_in[k] = !valid_ff[k] || adv_in[k+1];
      end
      valid_in[0] = adv_in[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < NS; k++) begin
         valid_in[k] = adv_in[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !adv_in[0];
   assign rsp_valid = valid_ff[NS-1];

   hsvrgb_datapath #(
      .HUE_FRAC_BITS (HUE_FRAC_BITS)
   ) u_datapath (
      .clock       (clock),
      .stage_en    (adv_in),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

### rtl/core/hsvrgb_datapath.sv
// ----------------------------------------------------------------------------
// hsvrgb_datapath
// seven-stage arithmetic pipeline: sector split, p/q/t products, division by
// constants through reciprocal multiply with one correction, sector routing
// ----------------------------------------------------------------------------
`default_nettype none

module hsvrgb_datapath #(
   parameter int HUE_FRAC_BITS = hsvrgb_pkg::HUE_FRAC_BITS_DEF
) (
   input  wire logic                             clock,
   input  wire logic [hsvrgb_pkg::STAGES-1:0]    stage_en,
   input  wire hsvrgb_pkg::req_type              req_payload,
   output      hsvrgb_pkg::rsp_type              rsp_payload
);

   localparam int CB       = hsvrgb_pkg::CHANNEL_BITS;
   localparam int SECTOR   = 60 << HUE_FRAC_BITS;
   localparam int CIRCLE   = 360 << HUE_FRAC_BITS;
   localparam int MAXV     = (1 << CB) - 1;
   localparam int MW       = MAXV * SECTOR;
   localparam int F_W      = $clog2(SECTOR);
   localparam int G_W      = $clog2(SECTOR + 1);
   localparam int MW_W     = $clog2(MW + 1);
   localparam int X_W      = CB + MW_W;
   localparam int XP_W     = 2 * CB;
   localparam int R_W      = CB + 2;
   localparam int PQ_W     = X_W + R_W;
   localparam int PP_W     = XP_W + R_W;

   localparam logic [R_W-1:0]  RQ       = R_W'((64'd1 << X_W) / MW);
   localparam logic [R_W-1:0]  RP       = R_W'((64'd1 << XP_W) / MAXV);
   localparam logic [MW_W-1:0] MW_C     = MW_W'(MW);
   localparam logic [G_W-1:0]  SECTOR_C = G_W'(SECTOR);
   localparam logic [CB-1:0]   MAXV_C   = CB'(MAXV);

   localparam logic [2:0] SEC_RED_YEL = 3'd0;
   localparam logic [2:0] SEC_YEL_GRN = 3'd1;
   localparam logic [2:0] SEC_GRN_CYN = 3'd2;
   localparam logic [2:0] SEC_CYN_BLU = 3'd3;
   localparam logic [2:0] SEC_BLU_MAG = 3'd4;

   // stage 1
   logic [31:0]     h_ext_in;
   logic [31:0]     base_in;
   logic [2:0]      sec_in;
   logic [F_W-1:0]  f1_ff;
   logic [CB-1:0]   s1_ff, v1_ff;
   logic [2:0]      sec1_ff;

   always_comb begin
      h_ext_in = 32'(req_payload.hue);
      if (h_ext_in >= 32'(CIRCLE)) begin
         h_ext_in = '0;
      end
      sec_in  = SEC_RED_YEL;
      base_in = '0;
      for (int k = 1; k < 6; k++) begin
         if (h_ext_in >= 32'(k * SECTOR)) begin
            sec_in  = 3'(k);
            base_in = 32'(k * SECTOR);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         f1_ff   <= F_W'(h_ext_in - base_in);
         s1_ff   <= req_payload.saturation;
         v1_ff   <= req_payload.brightness;
         sec1_ff <= sec_in;
      end
   end

   // stage 2
   logic [G_W-1:0]  g_in;
   logic [MW_W-1:0] sf2_ff, sg2_ff;
   logic [XP_W-1:0] vp2_ff;
   logic [CB-1:0]   v2_ff;
   logic [2:0]      sec2_ff;

   assign g_in = SECTOR_C - G_W'(f1_ff);

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         sf2_ff  <= MW_W'(s1_ff) * MW_W'(f1_ff);
         sg2_ff  <= MW_W'(s1_ff) * MW_W'(g_in);
         vp2_ff  <= XP_W'(v1_ff) * XP_W'(MAXV_C - s1_ff);
         v2_ff   <= v1_ff;
         sec2_ff <= sec1_ff;
      end
   end

   // stage 3
   logic [MW_W-1:0] nq3_ff, nt3_ff;
   logic [XP_W-1:0] vp3_ff;
   logic [CB-1:0]   v3_ff;
   logic [2:0]      sec3_ff;

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         nq3_ff  <= MW_C - sf2_ff;
         nt3_ff  <= MW_C - sg2_ff;
         vp3_ff  <= vp2_ff;
         v3_ff   <= v2_ff;
         sec3_ff <= sec2_ff;
      end
   end

   // stage 4
   logic [X_W-1:0]  xq4_ff, xt4_ff;
   logic [XP_W-1:0] xp4_ff;
   logic [CB-1:0]   v4_ff;
   logic [2:0]      sec4_ff;

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         xq4_ff  <= X_W'(v3_ff) * X_W'(nq3_ff);
         xt4_ff  <= X_W'(v3_ff) * X_W'(nt3_ff);
         xp4_ff  <= vp3_ff;
         v4_ff   <= v3_ff;
         sec4_ff <= sec3_ff;
      end
   end

   // stage 5: quotient estimate, low by at most one
   logic [PQ_W-1:0] pq_in, pt_in;
   logic [PP_W-1:0] pp_in;
   logic [CB-1:0]   eq5_ff, et5_ff, ep5_ff;
   logic [X_W-1:0]  xq5_ff, xt5_ff;
   logic [XP_W-1:0] xp5_ff;
   logic [CB-1:0]   v5_ff;
   logic [2:0]      sec5_ff;

   assign pq_in = PQ_W'(xq4_ff) * PQ_W'(RQ);
   assign pt_in = PQ_W'(xt4_ff) * PQ_W'(RQ);
   assign pp_in = PP_W'(xp4_ff) * PP_W'(RP);

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         eq5_ff  <= pq_in[X_W+CB-1:X_W];
         et5_ff  <= pt_in[X_W+CB-1:X_W];
         ep5_ff  <= pp_in[XP_W+CB-1:XP_W];
         xq5_ff  <= xq4_ff;
         xt5_ff  <= xt4_ff;
         xp5_ff  <= xp4_ff;
         v5_ff   <= v4_ff;
         sec5_ff <= sec4_ff;
      end
   end

   // stage 6: estimate times divisor
   logic [X_W-1:0]  bq6_ff, bt6_ff, xq6_ff, xt6_ff;
   logic [XP_W-1:0] bp6_ff, xp6_ff;
   logic [CB-1:0]   eq6_ff, et6_ff, ep6_ff, v6_ff;
   logic [2:0]      sec6_ff;

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         bq6_ff  <= X_W'(eq5_ff) * X_W'(MW_C);
         bt6_ff  <= X_W'(et5_ff) * X_W'(MW_C);
         bp6_ff  <= XP_W'(ep5_ff) * XP_W'(MAXV_C);
         xq6_ff  <= xq5_ff;
         xt6_ff  <= xt5_ff;
         xp6_ff  <= xp5_ff;
         eq6_ff  <= eq5_ff;
         et6_ff  <= et5_ff;
         ep6_ff  <= ep5_ff;
         v6_ff   <= v5_ff;
         sec6_ff <= sec5_ff;
      end
   end

   // stage 7: correction and routing
   logic [X_W-1:0]  rq_in, rt_in;
   logic [XP_W-1:0] rp_in;
   logic [CB-1:0]   q_in, t_in, p_in;
   hsvrgb_pkg::rsp_type rgb_in, rgb7_ff;

   always_comb begin
      rq_in = xq6_ff - bq6_ff;
      rt_in = xt6_ff - bt6_ff;
      rp_in = xp6_ff - bp6_ff;
      q_in  = eq6_ff + CB'(rq_in >= X_W'(MW_C));
      t_in  = et6_ff + CB'(rt_in >= X_W'(MW_C));
      p_in  = ep6_ff + CB'(rp_in >= XP_W'(MAXV_C));
      case (sec6_ff)
         SEC_RED_YEL: rgb_in = '{red: v6_ff, green: t_in,  blue: p_in};
         SEC_YEL_GRN: rgb_in = '{red: q_in,  green: v6_ff, blue: p_in};
         SEC_GRN_CYN: rgb_in = '{red: p_in,  green: v6_ff, blue: t_in};
         SEC_CYN_BLU: rgb_in = '{red: p_in,  green: q_in,  blue: v6_ff};
         SEC_BLU_MAG: rgb_in = '{red: t_in,  green: p_in,  blue: v6_ff};
         default:     rgb_in = '{red: v6_ff, green: p_in,  blue: q_in};
      endcase
   end

   always_ff @(posedge clock) begin
      if (stage_en[6]) begin
         rgb7_ff <= rgb_in;
      end
   end

   assign rsp_payload = rgb7_ff;

endmodule

`default_nettype wire

### rtl/core/hsvrgb_checker.sv
// ----------------------------------------------------------------------------
// hsvrgb_checker
// port-level checks of the converter, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module hsvrgb_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_stall,
   input wire hsvrgb_pkg::req_type  req_payload,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_stall,
   input wire hsvrgb_pkg::rsp_type  rsp_payload
);

   // reset empties the pipeline
   `ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)

   // an empty output stage means every stage can move
   `ASSERT_IMPLY(a_empty_ready, clock, 1'b0, !rsp_valid, !req_stall)

   // a held result stays put
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_payload))

   // a stalled request transaction stays offered and unchanged
   `ASSERT_NEXT(a_req_hold, clock, reset, req_valid && req_stall,
      req_valid && $stable(req_payload))

endmodule

bind hsv_to_rgb_converter hsvrgb_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

`default_nettype wire

### tb/hsv_to_rgb_converter_checker.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_checker
// watches both channels of the converter, predicts every color and compares
//
// each accepted request transaction is converted to rgb by an independent
// fixed-point model and queued; each accepted response transaction is
// compared field by field with the oldest queued color
// ----------------------------------------------------------------------------

module hsv_to_rgb_converter_checker #(
   parameter int HUE_FRAC_BITS = hsvrgb_pkg::HUE_FRAC_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  hsvrgb_pkg::req_type req_payload,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  hsvrgb_pkg::rsp_type rsp_payload,
   output int                  error_count,
   output int                  pending_count,
   output int                  checked_count
);

   timeunit 1ns;
   timeprecision 1ps;

   localparam longint LEVEL_MAX    = (longint'(1) << hsvrgb_pkg::CHANNEL_BITS) - 1;
   localparam longint SECTOR_CODES = longint'(60) << HUE_FRAC_BITS;
   localparam longint CIRCLE_CODES = longint'(360) << HUE_FRAC_BITS;

   hsvrgb_pkg::rsp_type expected_colors[$];

   function automatic hsvrgb_pkg::rsp_type convert_color(hsvrgb_pkg::req_type color);
      longint  h, s, v, sector, frac, full, p, q, t;
      longint  r, g, b;
      hsvrgb_pkg::rsp_type rgb;
      h = longint'(color.hue);
      s = longint'(color.saturation);
      v = longint'(color.brightness);
      if (s == 0) begin
         r = v;
         g = v;
         b = v;
      end else begin
         if (h >= CIRCLE_CODES) begin
            h = 0;
         end
         sector = h / SECTOR_CODES;
         frac   = h % SECTOR_CODES;
         full   = LEVEL_MAX * SECTOR_CODES;
         p = (v * (LEVEL_MAX - s)) / LEVEL_MAX;
         q = (v * (full - s * frac)) / full;
         t = (v * (full - s * (SECTOR_CODES - frac))) / full;
         case (sector)
            0: begin r = v; g = t; b = p; end
            1: begin r = q; g = v; b = p; end
            2: begin r = p; g = v; b = t; end
            3: begin r = p; g = q; b = v; end
            4: begin r = t; g = p; b = v; end
            default: begin r = v; g = p; b = q; end
         endcase
      end
      rgb.red   = r[hsvrgb_pkg::CHANNEL_BITS-1:0];
      rgb.green = g[hsvrgb_pkg::CHANNEL_BITS-1:0];
      rgb.blue  = b[hsvrgb_pkg::CHANNEL_BITS-1:0];
      return rgb;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("%0t mismatch: %s got %0d expected %0d", $time, what, got, want);
      error_count++;
   endtask

   initial begin
      error_count   = 0;
      pending_count = 0;
      checked_count = 0;
   end

   always @(posedge clock) begin
      hsvrgb_pkg::rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_colors.push_back(convert_color(req_payload));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_colors.size() == 0) begin
               report_mismatch("unexpected response, count", checked_count, -1);
            end else begin
               want = expected_colors.pop_front();
               if (rsp_payload.red !== want.red) begin
                  report_mismatch("red", int'(rsp_payload.red), int'(want.red));
               end
               if (rsp_payload.green !== want.green) begin
                  report_mismatch("green", int'(rsp_payload.green), int'(want.green));
               end
               if (rsp_payload.blue !== want.blue) begin
                  report_mismatch("blue", int'(rsp_payload.blue), int'(want.blue));
               end
            end
            checked_count++;
         end
         pending_count <= expected_colors.size();
      end
   end

endmodule

### tb/tb_hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// tb_hsv_to_rgb_converter
// stimulus and verdict for the hsv to rgb converter
//
// drives a directed set of edge colors followed by random colors, with
// random idling on both channels, a stretch without idling and one long
// response hold-off that fills the pipeline; checking lives in the checker
// ----------------------------------------------------------------------------

module tb_hsv_to_rgb_converter;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 950;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 60;
   localparam int HUE_CIRCLE   = 360 << hsvrgb_pkg::HUE_FRAC_BITS_DEF;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   hsvrgb_pkg::req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   hsvrgb_pkg::rsp_type rsp_payload;

   logic    quiet;
   logic    hold_request;
   int      error_count;
   int      pending_count;
   int      checked_count;
   int      cycle_count;
   int      sent_count;

   hsv_to_rgb_converter i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   hsv_to_rgb_converter_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_payload   (rsp_payload),
      .error_count   (error_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // response side: random stall, quiet stretch, one long hold-off
   initial begin
      int  hold_left;
      bit  hold_done;
      hold_left = 0;
      hold_done = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (hold_request && !hold_done) begin
            hold_done = 1;
            hold_left = HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else if (quiet) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < 10);
         end
      end
   end

   function automatic hsvrgb_pkg::req_type make_color(int h, int s, int v);
      hsvrgb_pkg::req_type color;
      color.hue        = h[hsvrgb_pkg::HUE_BITS-1:0];
      color.saturation = s[hsvrgb_pkg::CHANNEL_BITS-1:0];
      color.brightness = v[hsvrgb_pkg::CHANNEL_BITS-1:0];
      return color;
   endfunction

   function automatic hsvrgb_pkg::req_type random_color();
      int h, s, v, pick;
      pick = $urandom_range(99);
      if (pick < 70) begin
         h = $urandom_range(HUE_CIRCLE - 1);
      end else if (pick < 85) begin
         h = $urandom_range((1 << hsvrgb_pkg::HUE_BITS) - 1, HUE_CIRCLE);
      end else begin
         h = $urandom_range((1 << hsvrgb_pkg::HUE_BITS) - 1);
      end
      pick = $urandom_range(99);
      s = (pick < 10) ? 0 : (pick < 20) ? 255 : $urandom_range(255);
      pick = $urandom_range(99);
      v = (pick < 5) ? 0 : (pick < 10) ? 255 : $urandom_range(255);
      return make_color(h, s, v);
   endfunction

   task automatic send_color(hsvrgb_pkg::req_type color, bit may_idle);
      if (may_idle && $urandom_range(99) < 10) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= color;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
   endtask

   initial begin
      hsvrgb_pkg::req_type directed[$];
      int      i;
      cycle_count  = 0;
      sent_count   = 0;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_payload  <= '0;
      quiet        <= 1'b0;
      hold_request <= 1'b0;

      // full circle and wrapped hues, sector edges, grey and dark colors
      directed = {
         make_color(0, 255, 255),    make_color(5759, 255, 255),
         make_color(5760, 255, 255), make_color(8191, 255, 255),
         make_color(960, 255, 255),  make_color(1920, 255, 200),
         make_color(2880, 255, 128), make_color(3840, 255, 77),
         make_color(4800, 255, 255), make_color(959, 200, 255),
         make_color(480, 128, 255),  make_color(1440, 255, 0),
         make_color(2400, 0, 123),   make_color(8191, 0, 255),
         make_color(0, 0, 0),        make_color(3000, 1, 255),
         make_color(4000, 255, 1),   make_color(5000, 170, 85),
         make_color(6000, 100, 200), make_color(100, 255, 255),
         make_color(1919, 254, 254), make_color(2881, 1, 1)
      };

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[k]) begin
         send_color(directed[k], 1'b1);
      end

      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 200) begin
            quiet <= 1'b1;
         end else if (i == 400) begin
            quiet <= 1'b0;
         end else if (i == 600) begin
            hold_request <= 1'b1;
         end
         send_color(random_color(), !(i >= 200 && i < 400));
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("summary: %0d colors sent, %0d responses checked", sent_count,
               checked_count);
      $display("covered grey, wrapped hues, sector edges and a %0d-cycle hold-off",
               HOLD_CYCLES);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/hsvrgb_pkg.sv
rtl/core/hsvrgb_datapath.sv
rtl/core/hsv_to_rgb_converter.sv
rtl/core/hsvrgb_checker.sv
tb/hsv_to_rgb_converter_checker.sv
tb/tb_hsv_to_rgb_converter.sv
